FILE: rtl/core/pn3d_pkg.sv
// Package for the 3D gradient noise unit: permutation ROM, widths and arithmetic helpers.
package pn3d_pkg;

    // Fixed formats of the datapath.
    localparam int CoordW = 24;
    localparam int CellW  = 8;
    localparam int TW     = 16;
    localparam int FadeW  = 17;
    localparam int GradW  = 19;
    localparam int OutW   = 17;

    typedef logic [CellW-1:0]        cell_t;
    typedef logic [TW-1:0]           frac_t;
    typedef logic [FadeW-1:0]        fade_t;
    typedef logic signed [GradW-1:0] grad_t;
    typedef logic [3:0]              hash_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Corner offset along one axis: t, or t minus one for the far corner.
    function automatic grad_t corner_ofs(input frac_t t, input logic far_side);
        grad_t base;
        base = grad_t'({3'b000, t});
        return far_side ? grad_t'(base - grad_t'(19'sd65536)) : base;
    endfunction

    // Dot product of one of the 16 gradient directions with the corner offset.
    function automatic grad_t grad_dot(input hash_t h, input grad_t x, input grad_t y,
                                       input grad_t z);
        grad_t u;
        grad_t v;
        grad_t su;
        grad_t sv;
        u  = (h < 4'd8) ? x : y;
        v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        su = h[0] ? grad_t'(-u) : u;
        sv = h[1] ? grad_t'(-v) : v;
        return grad_t'(su + sv);
    endfunction

    // Linear blend a + floor(w * (b - a) / 2^16); the result stays between a and b.
    function automatic grad_t blend(input fade_t w, input grad_t a, input grad_t b);
        logic signed [GradW:0]        diff;
        logic signed [GradW+FadeW+1:0] prod;
        diff = {b[GradW-1], b} - {a[GradW-1], a};
        prod = $signed({1'b0, w}) * diff;
        return grad_t'(a + grad_t'(prod >>> 16));
    endfunction

endpackage

FILE: rtl/core/perlin_noise_3d_unit.sv
// Top level of the pipelined 3D improved gradient noise unit.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  point   | s_valid s_ready s_x/y/z_coord           | in
//  noise   | m_valid m_ready m_noise_value           | out
//
// One point enters per cycle while the pipeline is not stalled; each result leaves from the eighth stage.
// The eight stages are: input register, first hash level and t^2, second hash level,
// corner hashes and fade product, gradients, then x, y and z blends with the clamp.
// The whole pipeline advances together whenever the output register is empty or taken.
// A stall freezes every stage, so nothing is lost or repeated; reset clears valid bits only.
module perlin_noise_3d_unit
    import pn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CoordW-1:0] s_x_coord,
    input  logic [CoordW-1:0] s_y_coord,
    input  logic [CoordW-1:0] s_z_coord,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OutW-1:0]   m_noise_value
);

    localparam int ExtW = CoordW + CellW + TW;

    logic  adv;
    logic  [7:0] vld_reg;

    cell_t cell_in [3];
    frac_t t_in    [3];

    // Stage registers.
    cell_t c1_reg [3];
    frac_t t1_reg [3];
    cell_t a2_reg, b2_reg, cz2_reg;
    frac_t t2_reg [3];
    logic  [31:0] tt2_reg [3];
    cell_t aa3_reg, ab3_reg, ba3_reg, bb3_reg;
    frac_t t3_reg [3];
    logic  [21:0] inner3_reg [3];
    logic  [47:0] cub3_reg [3];
    hash_t h4_reg [8];
    frac_t t4_reg [3];
    fade_t f4_reg [3];
    grad_t g5_reg [8];
    fade_t f5_reg [3];
    grad_t l6_reg [4];
    fade_t f6_reg [2];
    grad_t l7_reg [2];
    fade_t f7_reg;
    logic  [OutW-1:0] out_reg;

    // The whole pipeline moves when the output slot is free or being taken.
    assign adv     = !vld_reg[7] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[7];
    assign m_noise_value = out_reg;

    // Split each coordinate into cell index and Q0.16 fraction.
    always_comb begin
        logic [ExtW-1:0] ext [3];
        ext[0] = ExtW'(s_x_coord);
        ext[1] = ExtW'(s_y_coord);
        ext[2] = ExtW'(s_z_coord);
        for (int i = 0; i < 3; i++) begin
            cell_in[i] = ext[i][FRAC_BITS +: CellW];
            if (FRAC_BITS >= TW) begin
                t_in[i] = ext[i][FRAC_BITS-TW +: TW];
            end else begin
                t_in[i] = frac_t'(ext[i][FRAC_BITS-1:0] << (TW - FRAC_BITS));
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:0], s_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        logic  [31:0] cube;
        logic  [53:0] fprod;
        grad_t ofs [3][2];
        grad_t n_next;
        if (adv) begin
            // Stage 1: input register.
            for (int i = 0; i < 3; i++) begin
                c1_reg[i] <= cell_in[i];
                t1_reg[i] <= t_in[i];
            end

            // Stage 2: first hash level and t squared.
            a2_reg  <= cell_t'(PERM_ROM[c1_reg[0]] + c1_reg[1]);
            b2_reg  <= cell_t'(PERM_ROM[cell_t'(c1_reg[0] + 8'd1)] + c1_reg[1]);
            cz2_reg <= c1_reg[2];
            for (int i = 0; i < 3; i++) begin
                t2_reg[i]  <= t1_reg[i];
                tt2_reg[i] <= 32'(t1_reg[i]) * 32'(t1_reg[i]);
            end

            // Stage 3: second hash level, fade polynomial and t cubed.
            aa3_reg <= cell_t'(PERM_ROM[a2_reg] + cz2_reg);
            ab3_reg <= cell_t'(PERM_ROM[cell_t'(a2_reg + 8'd1)] + cz2_reg);
            ba3_reg <= cell_t'(PERM_ROM[b2_reg] + cz2_reg);
            bb3_reg <= cell_t'(PERM_ROM[cell_t'(b2_reg + 8'd1)] + cz2_reg);
            for (int i = 0; i < 3; i++) begin
                t3_reg[i]     <= t2_reg[i];
                inner3_reg[i] <= 22'((35'(tt2_reg[i]) * 35'd6) >> 16)
                               + 22'd655360 - 22'(20'(t2_reg[i]) * 20'd15);
                cub3_reg[i]   <= 48'(tt2_reg[i]) * 48'(t2_reg[i]);
            end

            // Stage 4: corner hashes and the fade weights.
            h4_reg[0] <= hash_t'(PERM_ROM[aa3_reg]);
            h4_reg[1] <= hash_t'(PERM_ROM[ba3_reg]);
            h4_reg[2] <= hash_t'(PERM_ROM[ab3_reg]);
            h4_reg[3] <= hash_t'(PERM_ROM[bb3_reg]);
            h4_reg[4] <= hash_t'(PERM_ROM[cell_t'(aa3_reg + 8'd1)]);
            h4_reg[5] <= hash_t'(PERM_ROM[cell_t'(ba3_reg + 8'd1)]);
            h4_reg[6] <= hash_t'(PERM_ROM[cell_t'(ab3_reg + 8'd1)]);
            h4_reg[7] <= hash_t'(PERM_ROM[cell_t'(bb3_reg + 8'd1)]);
            for (int i = 0; i < 3; i++) begin
                cube      = cub3_reg[i][47:16];
                fprod     = 54'(cube) * 54'(inner3_reg[i]);
                t4_reg[i] <= t3_reg[i];
                f4_reg[i] <= fade_t'(fprod >> 32);
            end

            // Stage 5: gradient dot products; corner index bits pick the far side.
            for (int i = 0; i < 3; i++) begin
                ofs[i][0] = corner_ofs(t4_reg[i], 1'b0);
                ofs[i][1] = corner_ofs(t4_reg[i], 1'b1);
                f5_reg[i] <= f4_reg[i];
            end
            for (int k = 0; k < 8; k++) begin
                g5_reg[k] <= grad_dot(h4_reg[k], ofs[0][k%2], ofs[1][(k/2)%2],
                                      ofs[2][k/4]);
            end

            // Stage 6: blend along x.
            for (int k = 0; k < 4; k++) begin
                l6_reg[k] <= blend(f5_reg[0], g5_reg[2*k], g5_reg[2*k+1]);
            end
            f6_reg[0] <= f5_reg[1];
            f6_reg[1] <= f5_reg[2];

            // Stage 7: blend along y.
            l7_reg[0] <= blend(f6_reg[0], l6_reg[0], l6_reg[1]);
            l7_reg[1] <= blend(f6_reg[0], l6_reg[2], l6_reg[3]);
            f7_reg    <= f6_reg[1];

            // Stage 8: blend along z, clamp to [-1, 1] and map to [0, 1].
            n_next = blend(f7_reg, l7_reg[0], l7_reg[1]);
            if (n_next < -grad_t'(19'sd65536)) begin
                out_reg <= '0;
            end else if (n_next > grad_t'(19'sd65536)) begin
                out_reg <= OutW'(65536);
            end else begin
                out_reg <= OutW'((n_next + grad_t'(19'sd65536)) >>> 1);
            end
        end
    end

`ifndef SYNTH
    // Reset empties the output slot.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // An item in stage one moves to stage two when the pipeline advances.
    a_valid_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && adv |=> vld_reg[1])
        else $error("valid bit lost between stages");

    // Fade weights never exceed one.
    a_fade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (f4_reg[0] <= 17'd65536 && f4_reg[1] <= 17'd65536
                        && f4_reg[2] <= 17'd65536))
        else $error("fade weight out of range");

    // The output stays within [0, 1].
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_noise_value <= 17'd65536)
        else $error("noise value out of range");
`endif

endmodule
